FILE: src/dht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg: shared types and constants of the descriptor handle table
// Beat structs, action and status codes, and the cell-chain structs.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int SLOTS       = 32;
    localparam int HANDLE_BITS = 32;
    localparam int FD_W        = 6;
    localparam int ACT_W       = 3;
    localparam int ST_W        = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REG    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEREG  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DUP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DUP2   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DUP3   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_EXEC   = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BADFD = 2'd1;
    localparam logic [ST_W-1:0] ST_INVAL = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]       action;
        logic [FD_W-1:0]        old_fd;
        logic [FD_W-1:0]        new_fd;
        logic [HANDLE_BITS-1:0] handle;
        logic                   want_cloexec;
        logic                   other_flags;
    } t_in_beat;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [FD_W-1:0]        result_fd;
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   close_notice;
        logic                   last;
    } t_out_beat;

    // query broadcast to every cell
    typedef struct packed {
        logic [FD_W-1:0]        old_fd;
        logic [FD_W-1:0]        new_fd;
        logic [HANDLE_BITS-1:0] key;
    } t_query;

    // single slot write broadcast to every cell
    typedef struct packed {
        logic                   en;
        logic [FD_W-1:0]        idx;
        logic [HANDLE_BITS-1:0] handle;
        logic                   cloexec;
    } t_wr_cmd;

    // values handed from cell to cell, lowest slot first
    typedef struct packed {
        logic [HANDLE_BITS-1:0] old_h;
        logic [HANDLE_BITS-1:0] new_h;
        logic                   free_found;
        logic [FD_W-1:0]        free_idx;
        logic                   match_found;
        logic [FD_W-1:0]        match_idx;
        logic                   exec_found;
        logic [FD_W-1:0]        exec_idx;
        logic [HANDLE_BITS-1:0] exec_h;
    } t_chain;

endpackage

FILE: src/dht_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_cell: one descriptor slot
// Holds the slot's handle and close-on-exec bit, and folds its own view of
// the current query into the chain passed on to the next slot.
// ----------------------------------------------------------------------------
module dht_cell
    import dht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FD_W-1:0]     i_idx,
    input  t_query              i_query,
    input  t_wr_cmd             i_wr,
    input  t_chain              i_chain,
    output t_chain              o_chain
);

    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_cloexec;
    logic                   w_occupied;

    assign w_occupied = (r_handle != '0);

    // take a write aimed at this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle  <= '0;
            r_cloexec <= 1'b0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_handle  <= i_wr.handle;
            r_cloexec <= i_wr.cloexec;
        end
    end

    // fold this slot into the chain; earlier slots keep priority
    always_comb begin
        o_chain = i_chain;
        if (i_query.old_fd == i_idx) begin
            o_chain.old_h = r_handle;
        end
        if (i_query.new_fd == i_idx) begin
            o_chain.new_h = r_handle;
        end
        if (!i_chain.free_found && !w_occupied) begin
            o_chain.free_found = 1'b1;
            o_chain.free_idx   = i_idx;
        end
        if (!i_chain.match_found && w_occupied && (r_handle == i_query.key)) begin
            o_chain.match_found = 1'b1;
            o_chain.match_idx   = i_idx;
        end
        if (!i_chain.exec_found && w_occupied && r_cloexec) begin
            o_chain.exec_found = 1'b1;
            o_chain.exec_idx   = i_idx;
            o_chain.exec_h     = r_handle;
        end
    end

endmodule

FILE: src/dht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_ctrl: request sequencer of the descriptor handle table
// Latches one request, reads the cell chain, issues slot writes and emits
// close notices and the final status beat through an output register.
// ----------------------------------------------------------------------------
module dht_ctrl
    import dht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  t_chain    i_chain,
    output t_query    o_query,
    output t_wr_cmd   o_wr
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state    r_state, n_state;
    t_in_beat  r_req, n_req;
    logic      r_noticed, n_noticed;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    t_out_beat w_res;
    t_wr_cmd   w_wr;
    logic      w_done;
    logic      w_set_noticed;
    logic      w_out_free;
    logic      w_fire;
    logic      w_new_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_query.old_fd = r_req.old_fd;
    assign o_query.new_fd = r_req.new_fd;
    assign o_query.key    = r_req.handle;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = (r_state == S_RUN) && w_out_free;
    assign w_new_ok   = ({1'b0, r_req.new_fd} < (FD_W + 1)'(SLOTS));

    // decide the next beat and slot write for the held request
    always_comb begin
        w_res         = '0;
        w_res.last    = 1'b1;
        w_wr          = '0;
        w_done        = 1'b1;
        w_set_noticed = 1'b0;
        unique case (r_req.action)
            ACT_LOOKUP: begin
                if (i_chain.old_h != '0) begin
                    w_res.status     = ST_OK;
                    w_res.result_fd  = r_req.old_fd;
                    w_res.handle_out = i_chain.old_h;
                end else begin
                    w_res.status = ST_BADFD;
                end
            end
            ACT_REG: begin
                if (r_req.handle == '0) begin
                    w_res.status = ST_INVAL;
                end else if (!i_chain.free_found) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_wr.en         = 1'b1;
                    w_wr.idx        = i_chain.free_idx;
                    w_wr.handle     = r_req.handle;
                    w_res.status    = ST_OK;
                    w_res.result_fd = i_chain.free_idx;
                end
            end
            ACT_DEREG: begin
                if ((r_req.handle != '0) && i_chain.match_found) begin
                    w_wr.en         = 1'b1;
                    w_wr.idx        = i_chain.match_idx;
                    w_res.status    = ST_OK;
                    w_res.result_fd = i_chain.match_idx;
                end else begin
                    w_res.status = ST_INVAL;
                end
            end
            ACT_DUP: begin
                if (i_chain.old_h == '0) begin
                    w_res.status = ST_BADFD;
                end else if (!i_chain.free_found) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_wr.en         = 1'b1;
                    w_wr.idx        = i_chain.free_idx;
                    w_wr.handle     = i_chain.old_h;
                    w_res.status    = ST_OK;
                    w_res.result_fd = i_chain.free_idx;
                end
            end
            ACT_DUP2, ACT_DUP3: begin
                if ((r_req.action == ACT_DUP3) &&
                    ((r_req.old_fd == r_req.new_fd) || r_req.other_flags)) begin
                    w_res.status = ST_INVAL;
                end else if ((i_chain.old_h == '0) || !w_new_ok) begin
                    w_res.status = ST_BADFD;
                end else if ((r_req.old_fd != r_req.new_fd) &&
                             (i_chain.new_h != '0) && !r_noticed) begin
                    // report the target's old handle before replacing it
                    w_res.result_fd    = r_req.new_fd;
                    w_res.handle_out   = i_chain.new_h;
                    w_res.close_notice = 1'b1;
                    w_res.last         = 1'b0;
                    w_done             = 1'b0;
                    w_set_noticed      = 1'b1;
                end else begin
                    w_wr.en         = (r_req.old_fd != r_req.new_fd);
                    w_wr.idx        = r_req.new_fd;
                    w_wr.handle     = i_chain.old_h;
                    w_wr.cloexec    = (r_req.action == ACT_DUP3) && r_req.want_cloexec;
                    w_res.status    = ST_OK;
                    w_res.result_fd = r_req.new_fd;
                end
            end
            ACT_EXEC: begin
                if (i_chain.exec_found) begin
                    // close the lowest close-on-exec slot, one per beat
                    w_wr.en            = 1'b1;
                    w_wr.idx           = i_chain.exec_idx;
                    w_res.result_fd    = i_chain.exec_idx;
                    w_res.handle_out   = i_chain.exec_h;
                    w_res.close_notice = 1'b1;
                    w_res.last         = 1'b0;
                    w_done             = 1'b0;
                end else begin
                    w_res.status = ST_OK;
                end
            end
            default: begin
                w_res.status = ST_INVAL;
            end
        endcase
    end

    // gate the slot write with the beat that carries it
    always_comb begin
        o_wr    = w_wr;
        o_wr.en = w_wr.en && w_fire;
    end

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_noticed   = r_noticed;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in_data;
                    n_noticed = 1'b0;
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = w_res;
                    if (w_set_noticed) begin
                        n_noticed = 1'b1;
                    end
                    if (w_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_noticed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_noticed   <= n_noticed;
            r_out_valid <= n_out_valid;
        end
        r_req <= n_req;
        r_out <= n_out;
    end

endmodule

FILE: src/descriptor_handle_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_handle_table: table of descriptor slots with close-on-exec
// Row of slot cells chained lowest slot first, driven by one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request beat:
//   lookup, register, deregister, dup, dup2, dup3 or exec. Output channel
//   (o_out_valid / i_out_ready / o_out_data) returns zero or more close-notice
//   beats followed by one status beat with last set.
//   One request is worked at a time. An accepted request is latched, decided
//   from the cell chain, and its status beat goes to the output register as the
//   sequencer returns to idle; only then is a new request taken. Dup2 or dup3
//   onto an occupied slot first emits one close-notice beat, exec one per closed
//   slot; each beat is one pass of the cell chain (lowest free, matching handle
//   and close-on-exec searches) plus at most one slot write.
//   When the receiver stalls, the pending beat holds in the output register
//   and the sequencer waits with the table untouched.
//   Reset (synchronous, active low) empties every slot, clears all
//   close-on-exec bits and drops any pending beat; the block is ready as soon
//   as reset is released.
// ----------------------------------------------------------------------------
module descriptor_handle_table
    import dht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_chain  w_chain [SLOTS+1];
    t_query  w_query;
    t_wr_cmd w_wr;

    // chain starts empty at the lowest slot
    assign w_chain[0] = '0;

    // row of slot cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        dht_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (FD_W'(g)),
            .i_query (w_query),
            .i_wr    (w_wr),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // request sequencer
    dht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_chain     (w_chain[SLOTS]),
        .o_query     (w_query),
        .o_wr        (w_wr)
    );

endmodule
